FILE: design/bilinear_image_rescaler_unit_defines.svh
// Assertion macros for the bilinear rescaler.
// Used by the top level; no other dependencies.
`ifndef BILINEAR_IMAGE_RESCALER_UNIT_DEFINES_SVH
`define BILINEAR_IMAGE_RESCALER_UNIT_DEFINES_SVH
`ifndef ASSERT_OFF
`define BIRU_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define BIRU_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define BIRU_ASSERT(label, prop, msg)
`define BIRU_ASSERT_ALWAYS(label, prop, msg)
`endif
`endif

FILE: design/biru_pkg.sv
// Types and codes shared by the bilinear rescaler.
// No dependencies.
`default_nettype none
package biru_pkg;

  localparam int COORD_W = 12;
  localparam int STEP_W  = 24;
  localparam int FRAC_W  = 16;

  typedef enum logic {
    OP_STORE   = 1'b0,
    OP_COMPUTE = 1'b1
  } opcode_t;

  typedef enum logic [2:0] {
    CFG_SOURCE_WIDTH  = 3'd0,
    CFG_SOURCE_HEIGHT = 3'd1,
    CFG_COLUMN_STEP   = 3'd2,
    CFG_ROW_STEP      = 3'd3,
    CFG_CHANNEL_COUNT = 3'd4
  } cfg_reg_t;

  typedef struct packed {
    logic               opcode;
    logic [COORD_W-1:0] pixel_column;
    logic [COORD_W-1:0] pixel_row;
    logic [7:0]         in_channel0;
    logic [7:0]         in_channel1;
    logic [7:0]         in_channel2;
    logic [7:0]         in_channel3;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_channel0;
    logic [7:0] out_channel1;
    logic [7:0] out_channel2;
    logic [7:0] out_channel3;
  } out_item_t;

endpackage
`default_nettype wire

FILE: design/biru_ram.sv
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
`default_nettype none
module biru_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule
`default_nettype wire

FILE: design/bilinear_image_rescaler_unit.sv
// Bilinear rescaler: six-stage pipeline, one beat per cycle in and out
// while the skid slot is empty. Stages, in order: in, multiply, clamp,
// RAM read, horizontal blend, vertical blend; a full skid slot stalls them all.
// Four RAM copies give the four neighbour reads in the same cycle; a skid slot
// on the output keeps nothing lost on a stall. Synchronous reset clears
// valid bits and resets config to defaults; the source store is undefined until written.
`default_nettype none
`include "bilinear_image_rescaler_unit_defines.svh"
module bilinear_image_rescaler_unit #(
  parameter int MAX_SOURCE_DIM = 256,
  parameter int MAX_DEST_DIM   = 4096
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_write,
  input  logic [2:0]          cfg_index,
  input  logic [23:0]         cfg_data,
  input  logic                in_valid,
  output logic                in_ready,
  input  biru_pkg::in_item_t  in_item,
  output logic                out_valid,
  input  logic                out_ready,
  output biru_pkg::out_item_t out_item
);
  import biru_pkg::*;

  localparam int DEPTH = MAX_SOURCE_DIM * MAX_SOURCE_DIM;
  localparam int AW    = $clog2(MAX_SOURCE_DIM);
  localparam int MW    = $clog2(DEPTH);
  localparam int DW    = $clog2(MAX_SOURCE_DIM + 1);
  localparam int PW    = COORD_W + STEP_W;
  localparam int IW    = PW - FRAC_W;

  // configuration
  logic [8:0]        source_width, source_height;
  logic [STEP_W-1:0] column_step, row_step;
  logic [2:0]        channel_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      source_width  <= 9'd256;
      source_height <= 9'd256;
      column_step   <= 24'd65536;
      row_step      <= 24'd65536;
      channel_count <= 3'd3;
    end else if (cfg_write) begin
      unique case (cfg_index)
        CFG_SOURCE_WIDTH:  source_width  <= cfg_data[8:0];
        CFG_SOURCE_HEIGHT: source_height <= cfg_data[8:0];
        CFG_COLUMN_STEP:   column_step   <= cfg_data;
        CFG_ROW_STEP:      row_step      <= cfg_data;
        CFG_CHANNEL_COUNT: channel_count <= cfg_data[2:0];
        default: ;
      endcase
    end
  end

  logic [DW-1:0] w_eff, h_eff;
  logic [AW-1:0] last_x, last_y;

  always_comb begin
    if (source_width == 9'd0) w_eff = DW'(1);
    else if (32'(source_width) > MAX_SOURCE_DIM) w_eff = DW'(MAX_SOURCE_DIM);
    else w_eff = DW'(source_width);
    if (source_height == 9'd0) h_eff = DW'(1);
    else if (32'(source_height) > MAX_SOURCE_DIM) h_eff = DW'(MAX_SOURCE_DIM);
    else h_eff = DW'(source_height);
    last_x = AW'(w_eff - DW'(1));
    last_y = AW'(h_eff - DW'(1));
  end

  // pipeline advances whenever the skid slot is empty
  logic             skid_v;
  out_item_t        skid_d;
  logic             en;
  assign en       = !skid_v;
  assign in_ready = en;

  // stage 1: input register
  logic               s1_v, s1_op;
  logic [COORD_W-1:0] s1_col, s1_row;
  logic [31:0]        s1_word;

  always_ff @(posedge clk) begin
    if (rst) s1_v <= 1'b0;
    else if (en) s1_v <= in_valid;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_op   <= in_item.opcode;
      s1_col  <= in_item.pixel_column;
      s1_row  <= in_item.pixel_row;
      s1_word <= {in_item.in_channel3, in_item.in_channel2,
                  in_item.in_channel1, in_item.in_channel0};
    end
  end

  // stage 2: coordinate times step, store address
  logic               s2_v, s2_op, s2_wr_ok;
  logic [PW-1:0]      s2_posx, s2_posy;
  logic [MW-1:0]      s2_waddr;
  logic [31:0]        s2_word;
  logic [COORD_W-1:0] dcol, drow;

  always_comb begin
    dcol = (32'(s1_col) >= MAX_DEST_DIM) ? COORD_W'(MAX_DEST_DIM - 1) : s1_col;
    drow = (32'(s1_row) >= MAX_DEST_DIM) ? COORD_W'(MAX_DEST_DIM - 1) : s1_row;
  end

  always_ff @(posedge clk) begin
    if (rst) s2_v <= 1'b0;
    else if (en) s2_v <= s1_v;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_op    <= s1_op;
      s2_posx  <= PW'(dcol) * PW'(column_step);
      s2_posy  <= PW'(drow) * PW'(row_step);
      s2_wr_ok <= (32'(s1_col) < MAX_SOURCE_DIM) && (32'(s1_row) < MAX_SOURCE_DIM);
      s2_waddr <= MW'(32'(s1_row) * MAX_SOURCE_DIM + 32'(s1_col));
      s2_word  <= s1_word;
    end
  end

  // stage 3: clamp to the source edge, split off fractions
  logic              s3_v, s3_op, s3_wr_ok;
  logic [AW-1:0]     s3_x0, s3_x1, s3_y0, s3_y1;
  logic [FRAC_W-1:0] s3_fx, s3_fy;
  logic [MW-1:0]     s3_waddr;
  logic [31:0]       s3_word;
  logic [IW-1:0]     ipx, ipy;
  logic [AW-1:0]     x0, y0;

  always_comb begin
    ipx = s2_posx[PW-1:FRAC_W];
    ipy = s2_posy[PW-1:FRAC_W];
    x0  = (ipx > IW'(last_x)) ? last_x : AW'(ipx);
    y0  = (ipy > IW'(last_y)) ? last_y : AW'(ipy);
  end

  always_ff @(posedge clk) begin
    if (rst) s3_v <= 1'b0;
    else if (en) s3_v <= s2_v;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s3_op    <= s2_op;
      s3_x0    <= x0;
      s3_x1    <= (x0 == last_x) ? x0 : x0 + AW'(1);
      s3_y0    <= y0;
      s3_y1    <= (y0 == last_y) ? y0 : y0 + AW'(1);
      s3_fx    <= s2_posx[FRAC_W-1:0];
      s3_fy    <= s2_posy[FRAC_W-1:0];
      s3_wr_ok <= s2_wr_ok;
      s3_waddr <= s2_waddr;
      s3_word  <= s2_word;
    end
  end

  // stage 4: four RAM copies, one neighbour each
  logic          ram_we;
  logic [MW-1:0] raddr [4];
  logic [31:0]   rdata [4];

  assign ram_we = en && s3_v && (s3_op == OP_STORE) && s3_wr_ok;

  always_comb begin
    raddr[0] = MW'(32'(s3_y0) * MAX_SOURCE_DIM + 32'(s3_x0));
    raddr[1] = MW'(32'(s3_y0) * MAX_SOURCE_DIM + 32'(s3_x1));
    raddr[2] = MW'(32'(s3_y1) * MAX_SOURCE_DIM + 32'(s3_x0));
    raddr[3] = MW'(32'(s3_y1) * MAX_SOURCE_DIM + 32'(s3_x1));
  end

  for (genvar g = 0; g < 4; g++) begin : g_copy
    biru_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_ram (
      .clk   (clk),
      .we    (ram_we),
      .waddr (s3_waddr),
      .wdata (s3_word),
      .re    (en),
      .raddr (raddr[g]),
      .rdata (rdata[g])
    );
  end

  logic              s4_v;
  logic [FRAC_W-1:0] s4_fx, s4_fy;

  always_ff @(posedge clk) begin
    if (rst) s4_v <= 1'b0;
    else if (en) s4_v <= s3_v && (s3_op == OP_COMPUTE);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s4_fx <= s3_fx;
      s4_fy <= s3_fy;
    end
  end

  // stage 5: horizontal blend
  logic              s5_v;
  logic [FRAC_W-1:0] s5_fy;
  logic [23:0]       s5_top [4];
  logic [23:0]       s5_bot [4];
  logic [16:0]       wfx, ofx;

  assign wfx = 17'(s4_fx);
  assign ofx = 17'h10000 - wfx;

  always_ff @(posedge clk) begin
    if (rst) s5_v <= 1'b0;
    else if (en) s5_v <= s4_v;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s5_fy <= s4_fy;
      for (int k = 0; k < 4; k++) begin
        s5_top[k] <= 24'(25'(rdata[0][8*k +: 8]) * 25'(ofx)
                       + 25'(rdata[1][8*k +: 8]) * 25'(wfx));
        s5_bot[k] <= 24'(25'(rdata[2][8*k +: 8]) * 25'(ofx)
                       + 25'(rdata[3][8*k +: 8]) * 25'(wfx));
      end
    end
  end

  // stage 6: vertical blend, channel mask
  logic        s6_v;
  out_item_t   s6_d;
  logic [16:0] wfy, ofy;
  logic [41:0] vsum [4];
  logic [7:0]  chan [4];

  assign wfy = 17'(s5_fy);
  assign ofy = 17'h10000 - wfy;

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      vsum[k] = 42'(s5_top[k]) * 42'(ofy) + 42'(s5_bot[k]) * 42'(wfy);
      chan[k] = (3'(k) < channel_count) ? vsum[k][39:32] : 8'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) s6_v <= 1'b0;
    else if (en) s6_v <= s5_v;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s6_d.out_channel0 <= chan[0];
      s6_d.out_channel1 <= chan[1];
      s6_d.out_channel2 <= chan[2];
      s6_d.out_channel3 <= chan[3];
    end
  end

  // skid slot catches the beat that would be overwritten on a stall
  always_ff @(posedge clk) begin
    if (rst) begin
      skid_v <= 1'b0;
    end else if (skid_v) begin
      if (out_ready) skid_v <= 1'b0;
    end else if (s6_v && !out_ready) begin
      skid_v <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!skid_v) skid_d <= s6_d;
  end

  assign out_valid = skid_v || s6_v;
  assign out_item  = skid_v ? skid_d : s6_d;

  `BIRU_ASSERT(a_skid_holds, skid_v && !out_ready |=> skid_v, "skid beat dropped")
  `BIRU_ASSERT(a_neigh_adjacent, s3_v |-> (s3_x1 == s3_x0 || s3_x1 == s3_x0 + AW'(1)), "bad x neighbour")
  `BIRU_ASSERT(a_skid_full_blocks, skid_v |=> !s6_v || $stable(s6_d) || !$past(skid_v), "stage 6 moved")
  `BIRU_ASSERT(a_no_write_stalled, ram_we |-> !skid_v, "store written during stall")
  `BIRU_ASSERT_ALWAYS(a_reset_empty, $past(rst) |-> !out_valid, "result after reset")
endmodule
`default_nettype wire

FILE: verif/tb_bilinear_image_rescaler_unit.sv
// Self-checking bench for bilinear_image_rescaler_unit: random valid/ready traffic,
// with a scoreboard class that predicts each interpolated pixel.
// Depends on biru_pkg and the design top level only.
`timescale 1ns / 100ps
module tb_bilinear_image_rescaler_unit;
  import biru_pkg::*;

  localparam int SRC_DIM = 256;
  localparam int DST_DIM = 4096;
  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_CYCLES = 20;

  class rescale_scoreboard;
    logic [31:0]   src_mem [SRC_DIM*SRC_DIM];
    int unsigned   width_reg, height_reg, col_step_reg, row_step_reg, chan_reg;
    out_item_t     pending_pixels[$];
    int            mismatches;

    function new();
      width_reg = 256; height_reg = 256;
      col_step_reg = 65536; row_step_reg = 65536; chan_reg = 3;
      mismatches = 0;
    endfunction

    function void set_reg(cfg_reg_t idx, logic [23:0] val);
      case (idx)
        CFG_SOURCE_WIDTH:  width_reg    = val[8:0];
        CFG_SOURCE_HEIGHT: height_reg   = val[8:0];
        CFG_COLUMN_STEP:   col_step_reg = val;
        CFG_ROW_STEP:      row_step_reg = val;
        CFG_CHANNEL_COUNT: chan_reg     = val[2:0];
        default: ;
      endcase
    endfunction

    function int unsigned eff_dim(int unsigned v);
      if (v == 0) return 1;
      if (v > SRC_DIM) return SRC_DIM;
      return v;
    endfunction

    function void split_pos(int unsigned coord, int unsigned step, int unsigned dim,
                            output int unsigned lo, output int unsigned hi,
                            output int unsigned frac);
      longint unsigned pos;
      longint unsigned ip;
      int unsigned     last;
      pos  = longint'(coord) * longint'(step);
      ip   = pos >> 16;
      last = dim - 1;
      lo   = (ip > last) ? last : int'(ip);
      hi   = (lo + 1 > last) ? last : lo + 1;
      frac = pos[15:0];
    endfunction

    function void note_input(in_item_t it);
      int unsigned     col, row, x0, x1, fx, y0, y1, fy;
      logic [31:0]     p00, p10, p01, p11;
      longint unsigned c00, c10, c01, c11, top, bot, v;
      logic [7:0]      chan [4];
      out_item_t       px;
      if (it.opcode == OP_STORE) begin
        if (it.pixel_column < SRC_DIM && it.pixel_row < SRC_DIM)
          src_mem[it.pixel_row*SRC_DIM + it.pixel_column] =
            {it.in_channel3, it.in_channel2, it.in_channel1, it.in_channel0};
        return;
      end
      col = (it.pixel_column >= DST_DIM) ? DST_DIM-1 : it.pixel_column;
      row = (it.pixel_row >= DST_DIM) ? DST_DIM-1 : it.pixel_row;
      split_pos(col, col_step_reg, eff_dim(width_reg), x0, x1, fx);
      split_pos(row, row_step_reg, eff_dim(height_reg), y0, y1, fy);
      p00 = src_mem[y0*SRC_DIM + x0];
      p10 = src_mem[y0*SRC_DIM + x1];
      p01 = src_mem[y1*SRC_DIM + x0];
      p11 = src_mem[y1*SRC_DIM + x1];
      for (int k = 0; k < 4; k++) begin
        c00 = p00[8*k +: 8]; c10 = p10[8*k +: 8];
        c01 = p01[8*k +: 8]; c11 = p11[8*k +: 8];
        top = c00*(65536-fx) + c10*fx;
        bot = c01*(65536-fx) + c11*fx;
        v = (top*(65536-fy) + bot*fy) >> 32;
        chan[k] = (k < chan_reg) ? v[7:0] : 8'd0;
      end
      px.out_channel0 = chan[0];
      px.out_channel1 = chan[1];
      px.out_channel2 = chan[2];
      px.out_channel3 = chan[3];
      pending_pixels.insert(pending_pixels.size(), px);
    endfunction

    function void check_result(out_item_t got);
      out_item_t want;
      if (pending_pixels.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result beat %h", got);
        return;
      end
      want = pending_pixels.pop_front();
      if (got.out_channel0 !== want.out_channel0 || got.out_channel1 !== want.out_channel1 ||
          got.out_channel2 !== want.out_channel2 || got.out_channel3 !== want.out_channel3) begin
        mismatches++;
        if (mismatches <= 10) $display("pixel mismatch: expected %h got %h", want, got);
      end
    endfunction
  endclass

  logic        clk, rst;
  logic        cfg_write;
  logic [2:0]  cfg_index;
  logic [23:0] cfg_data;
  logic        in_valid, in_ready, out_valid, out_ready;
  in_item_t    in_item;
  out_item_t   out_item;
  bit          steady;
  int          cycles;
  rescale_scoreboard sb;

  bilinear_image_rescaler_unit u_dut (
    .clk(clk), .rst(rst), .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready), .in_item(in_item),
    .out_valid(out_valid), .out_ready(out_ready), .out_item(out_item)
  );

  initial begin
    clk = 0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    if (!rst && in_valid && in_ready) sb.note_input(in_item);
    if (!rst && out_valid && out_ready) sb.check_result(out_item);
  end

  always @(posedge clk) out_ready <= steady || ($urandom_range(99) >= 31);

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("bilinear_image_rescaler_unit test failed");
      $finish;
    end
  end

  // idle cycles can come in runs; unless steady is set, roughly 31 in a hundred are idle
  task automatic send_beat(in_item_t it);
    while (!steady && $urandom_range(99) < 31) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= it;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic store_px(int unsigned col, int unsigned row);
    in_item_t it;
    it.opcode = OP_STORE;
    it.pixel_column = COORD_W'(col);
    it.pixel_row = COORD_W'(row);
    {it.in_channel3, it.in_channel2, it.in_channel1, it.in_channel0} = $urandom;
    send_beat(it);
  endtask

  task automatic compute_px(int unsigned col, int unsigned row);
    in_item_t it;
    it.opcode = OP_COMPUTE;
    it.pixel_column = COORD_W'(col);
    it.pixel_row = COORD_W'(row);
    {it.in_channel3, it.in_channel2, it.in_channel1, it.in_channel0} = $urandom;
    send_beat(it);
  endtask

  // wait for the pipe to drain before touching registers
  task automatic quiesce();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending_pixels.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // leaves cfg_write high; the caller drops it after the last write
  task automatic write_reg(cfg_reg_t idx, logic [23:0] val);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    sb.set_reg(idx, val);
    @(posedge clk);
  endtask

  // one setting: registers, fill the live region, then traffic
  task automatic run_phase(logic [23:0] w, logic [23:0] h, logic [23:0] cs,
                           logic [23:0] rs, logic [23:0] ch, int n_items);
    int unsigned ew, eh, pick;
    quiesce();
    write_reg(CFG_SOURCE_WIDTH, w);
    write_reg(CFG_SOURCE_HEIGHT, h);
    write_reg(CFG_COLUMN_STEP, cs);
    write_reg(CFG_ROW_STEP, rs);
    write_reg(CFG_CHANNEL_COUNT, ch);
    cfg_write <= 1'b0;
    ew = sb.eff_dim(w[8:0]);
    eh = sb.eff_dim(h[8:0]);
    for (int r = 0; r < eh; r++)
      for (int c = 0; c < ew; c++) store_px(c, r);
    for (int i = 0; i < n_items; i++) begin
      pick = $urandom_range(99);
      if (pick < 55)      compute_px($urandom_range(ew + 2), $urandom_range(eh + 2));
      else if (pick < 65) compute_px($urandom_range(DST_DIM-1), $urandom_range(DST_DIM-1));
      else if (pick < 88) store_px($urandom_range(ew-1), $urandom_range(eh-1));
      else                store_px($urandom_range(DST_DIM-1), $urandom_range(DST_DIM-1));
    end
  endtask

  initial begin
    logic [23:0] w, h;
    sb = new();
    rst = 1'b1; cfg_write = 1'b0; cfg_index = '0; cfg_data = '0;
    in_valid = 1'b0; in_item = '0; out_ready = 1'b0; steady = 1'b0; cycles = 0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: single-pixel image with sizes of zero, then edge coords
    run_phase(24'd0, 24'd0, 24'd0, 24'd0, 24'd0, 0);
    compute_px(0, 0);
    compute_px(DST_DIM-1, DST_DIM-1);
    store_px(SRC_DIM, 0);
    store_px(0, DST_DIM-1);
    compute_px(0, DST_DIM-1);
    run_phase(24'd2, 24'd2, 24'h008000, 24'h008000, 24'd4, 0);
    for (int r = 0; r < 4; r++)
      for (int c = 0; c < 4; c++) compute_px(c, r);
    compute_px(DST_DIM-1, 0);
    compute_px(0, DST_DIM-1);

    // size extremes: a full-width row and a full-height column
    run_phase(24'd256, 24'd1, 24'hFFFFFF, 24'd0, 24'd4, 40);
    run_phase(24'hFFFE00, 24'd511, 24'd0, 24'h00C000, 24'd7, 40);
    steady = 1'b1;
    run_phase(24'd8, 24'd8, 24'h00F000, 24'h00E000, 24'd4, 150);
    steady = 1'b0;
    for (int p = 0; p < 4; p++) begin
      w = 24'($urandom_range(10, 2));
      h = 24'($urandom_range(10, 2));
      run_phase(w, h,
                (p[0]) ? 24'($urandom) : 24'(((w-1) << 16) / $urandom_range(40, 2)),
                (p[0]) ? 24'(((h-1) << 16) / $urandom_range(40, 2)) : 24'($urandom),
                24'($urandom_range(7)), 80);
    end

    in_valid <= 1'b0;
    while (sb.pending_pixels.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.mismatches == 0)
      $display("bilinear_image_rescaler_unit test passed");
    else
      $display("bilinear_image_rescaler_unit test failed");
    $finish;
  end
endmodule

FILE: filelist.f
+incdir+design
design/biru_pkg.sv
design/biru_ram.sv
design/bilinear_image_rescaler_unit.sv
verif/tb_bilinear_image_rescaler_unit.sv
